// File: sv/dsq_pkg.sv
// ----------------------------------------------------------------------------
// dsq_pkg
// shared types and codes of the delta-list sleep queue
// ----------------------------------------------------------------------------
package dsq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_TICK   = 2'd1,
    OP_TAKE   = 2'd2,
    OP_REMOVE = 2'd3
  } dsq_op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_POS = 2'd3
  } dsq_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_EX,
    S_SHF_RD,
    S_SHF_EX,
    S_REM_RD,
    S_REM_EX,
    S_MOV_RD,
    S_MOV_EX,
    S_TCK_RD,
    S_TCK_EX,
    S_HEAD_RD,
    S_HEAD_EX
  } dsq_state_t;

  localparam int ID_W    = 16;
  localparam int DELAY_W = 16;
  localparam int POS_W   = 6;
  localparam int CNT_W   = 7;
  localparam int REM_W   = 16;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 64;

endpackage

// File: sv/delta_sleep_queue.sv
// ----------------------------------------------------------------------------
// delta_sleep_queue
// sleep queue held as a delta list in a single-port-write memory
// ----------------------------------------------------------------------------
// usage:
//   input stream: in_tuser carries the op (insert, tick, take, remove at
//   position); in_tdata carries thread id, delay and position. one request is
//   taken while in_tready is high, then the block is busy until its result is
//   built. output stream: one result per request with the taken id, the new
//   head id and remaining time, the entry count and a status code.
//   timing: every list access is a memory read followed by a process step,
//   so the walk visits one entry at a time. insert walks the whole list,
//   take/remove walk from the position to the end of the list; tick and
//   rejected requests touch only the head. the memory read port is the
//   limiting resource.
//   reset clears the entry count and both stream handshakes; memory contents
//   are never read past the count, so they need no clearing.
//   a finished result sits in the output register; the next request is still
//   taken while it waits, but its result waits until out_tready frees it.
// ----------------------------------------------------------------------------
module delta_sleep_queue
  import dsq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int TIME_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // thread_id, delay, position, pad
  input  logic [1:0]       in_tuser,   // op
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // taken_id, taken_valid, head_id,
                                       // head_remaining, head_valid,
                                       // entry_count, status, pad
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int TB = TIME_BITS;
  localparam int EW = ID_W + TB;
  localparam logic [31:0] TMAX32 = 32'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [TB-1:0] TMAX = {TB{1'b1}};
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  dsq_state_t state_r, state_nxt;

  logic [CW-1:0]    occ_r, occ_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic [TB-1:0]    t_r, t_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [ID_W-1:0]  car_id_r, car_id_nxt;
  logic [TB-1:0]    car_dl_r, car_dl_nxt;
  logic             first_r, first_nxt;
  logic [ID_W-1:0]  taken_id_r, taken_id_nxt;
  logic             taken_v_r, taken_v_nxt;
  dsq_status_t      status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic [EW-1:0]    mem [QUEUE_DEPTH];
  logic [EW-1:0]    rd_data_r;
  logic [AW-1:0]    mem_ra, mem_wa;
  logic [EW-1:0]    mem_wd;
  logic             mem_we;

  dsq_op_t          in_op;
  logic [ID_W-1:0]  in_thread_id;
  logic [DELAY_W-1:0] in_delay;
  logic [POS_W-1:0] in_position;
  logic [31:0]      delay32;
  logic [TB-1:0]    delay_sat;
  logic             in_acc;
  logic             occ_zero, occ_full, pos_bad;
  logic [ID_W-1:0]  rd_id;
  logic [TB-1:0]    rd_dl;
  logic [TB:0]      sum_ext;
  logic [TB-1:0]    sum_sat;
  logic [31:0]      head32;
  logic [REM_W-1:0] head_rem;
  logic [AW-1:0]    k_idx, k_prev_idx;

  assign in_op        = dsq_op_t'(in_tuser);
  assign in_thread_id = in_tdata[15:0];
  assign in_delay     = in_tdata[31:16];
  assign in_position  = in_tdata[37:32];
  assign in_acc       = in_tvalid && in_tready;
  assign in_tready    = (state_r == S_IDLE);
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

  assign delay32   = 32'(in_delay);
  assign delay_sat = (delay32 > TMAX32) ? TMAX : delay32[TB-1:0];
  assign occ_zero  = (occ_r == '0);
  assign occ_full  = (occ_r >= DEPTH_C);
  assign pos_bad   = (PW'(in_position) >= PW'(occ_r));

  assign rd_id      = rd_data_r[EW-1:TB];
  assign rd_dl      = rd_data_r[TB-1:0];
  assign sum_ext    = {1'b0, rd_dl} + {1'b0, car_dl_r};
  assign sum_sat    = sum_ext[TB] ? TMAX : sum_ext[TB-1:0];
  assign head32     = 32'(rd_dl);
  assign head_rem   = (head32 > 32'h0000_FFFF) ? 16'hFFFF : head32[15:0];
  assign k_idx      = k_r[AW-1:0];
  assign k_prev_idx = AW'(k_r - 1'b1);

  // list memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    t_r        <= t_nxt;
    id_r       <= id_nxt;
    car_id_r   <= car_id_nxt;
    car_dl_r   <= car_dl_nxt;
    first_r    <= first_nxt;
    taken_id_r <= taken_id_nxt;
    taken_v_r  <= taken_v_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_INSERT: state_nxt = occ_full ? S_HEAD_RD : S_INS_RD;
            OP_TICK:   state_nxt = occ_zero ? S_HEAD_RD : S_TCK_RD;
            OP_TAKE:   state_nxt = occ_zero ? S_HEAD_RD : S_REM_RD;
            OP_REMOVE: state_nxt = (occ_zero || pos_bad) ? S_HEAD_RD : S_REM_RD;
            default:   state_nxt = S_HEAD_RD;
          endcase
        end
      end
      S_INS_RD:  state_nxt = (k_r == occ_r) ? S_HEAD_RD : S_INS_EX;
      S_INS_EX:  state_nxt = (t_r > rd_dl) ? S_INS_RD : S_SHF_RD;
      S_SHF_RD:  state_nxt = (k_r == occ_r) ? S_HEAD_RD : S_SHF_EX;
      S_SHF_EX:  state_nxt = S_SHF_RD;
      S_REM_RD:  state_nxt = S_REM_EX;
      S_REM_EX:  state_nxt = S_MOV_RD;
      S_MOV_RD:  state_nxt = (k_r == occ_r) ? S_HEAD_RD : S_MOV_EX;
      S_MOV_EX:  state_nxt = S_MOV_RD;
      S_TCK_RD:  state_nxt = S_TCK_EX;
      S_TCK_EX:  state_nxt = S_HEAD_RD;
      S_HEAD_RD: state_nxt = S_HEAD_EX;
      S_HEAD_EX: state_nxt = (!out_valid_r || out_tready) ? S_IDLE : S_HEAD_EX;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    occ_nxt       = occ_r;
    k_nxt         = k_r;
    t_nxt         = t_r;
    id_nxt        = id_r;
    car_id_nxt    = car_id_r;
    car_dl_nxt    = car_dl_r;
    first_nxt     = first_r;
    taken_id_nxt  = taken_id_r;
    taken_v_nxt   = taken_v_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_ra        = '0;
    mem_wa        = k_idx;
    mem_wd        = {car_id_r, car_dl_r};
    mem_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          id_nxt       = in_thread_id;
          t_nxt        = delay_sat;
          k_nxt        = (in_op == OP_REMOVE) ? CW'(in_position) : '0;
          taken_id_nxt = '0;
          taken_v_nxt  = 1'b0;
          status_nxt   = ST_OK;
          unique case (in_op) inside
            OP_INSERT: if (occ_full) status_nxt = ST_FULL;
            OP_TICK, OP_TAKE: if (occ_zero) status_nxt = ST_EMPTY;
            OP_REMOVE: begin
              if (occ_zero) begin
                status_nxt = ST_EMPTY;
              end else if (pos_bad) begin
                status_nxt = ST_BAD_POS;
              end
            end
            default: status_nxt = ST_OK;
          endcase
        end
      end
      S_INS_RD: begin
        mem_ra = k_idx;
        if (k_r == occ_r) begin
          mem_we  = 1'b1;
          mem_wd  = {id_r, t_r};
          occ_nxt = occ_r + 1'b1;
        end
      end
      S_INS_EX: begin
        if (t_r > rd_dl) begin
          t_nxt = t_r - rd_dl;
        end else begin
          mem_we     = 1'b1;
          mem_wd     = {id_r, t_r};
          car_id_nxt = rd_id;
          car_dl_nxt = rd_dl - t_r;
        end
        k_nxt = k_r + 1'b1;
      end
      S_SHF_RD: begin
        mem_ra = k_idx;
        if (k_r == occ_r) begin
          mem_we  = 1'b1;
          occ_nxt = occ_r + 1'b1;
        end
      end
      S_SHF_EX: begin
        mem_we     = 1'b1;
        car_id_nxt = rd_id;
        car_dl_nxt = rd_dl;
        k_nxt      = k_r + 1'b1;
      end
      S_REM_RD: mem_ra = k_idx;
      S_REM_EX: begin
        taken_id_nxt = rd_id;
        taken_v_nxt  = 1'b1;
        car_dl_nxt   = rd_dl;
        first_nxt    = 1'b1;
        k_nxt        = k_r + 1'b1;
      end
      S_MOV_RD: begin
        mem_ra = k_idx;
        if (k_r == occ_r) begin
          occ_nxt = occ_r - 1'b1;
        end
      end
      S_MOV_EX: begin
        mem_we    = 1'b1;
        mem_wa    = k_prev_idx;
        mem_wd    = {rd_id, first_r ? sum_sat : rd_dl};
        first_nxt = 1'b0;
        k_nxt     = k_r + 1'b1;
      end
      S_TCK_RD: mem_ra = '0;
      S_TCK_EX: begin
        mem_wa = '0;
        mem_wd = {rd_id, rd_dl - 1'b1};
        mem_we = (rd_dl != '0);
      end
      S_HEAD_RD: mem_ra = '0;
      S_HEAD_EX: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[15:0]  = taken_id_r;
          out_data_nxt[16]    = taken_v_r;
          out_data_nxt[32:17] = occ_zero ? '0 : rd_id;
          out_data_nxt[48:33] = occ_zero ? '0 : head_rem;
          out_data_nxt[49]    = !occ_zero;
          out_data_nxt[56:50] = CNT_W'(occ_r);
          out_data_nxt[58:57] = status_r;
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

endmodule

// File: sv/dsq_checker.sv
// ----------------------------------------------------------------------------
// dsq_checker
// port-level checks of the delta-list sleep queue, bound to the top level
// ----------------------------------------------------------------------------
module dsq_checker
  import dsq_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // busy after taking a request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // empty head reads as zero
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[49] |-> out_tdata[48:17] == '0)
    else $error("empty queue shows a head");

  // no taken id without taken flag
  a_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[16] |-> out_tdata[15:0] == '0)
    else $error("stray taken id");

  // empty status means nothing taken and no head
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[58:57] == ST_EMPTY |-> !out_tdata[49] && !out_tdata[16])
    else $error("empty status with live entries");

endmodule

bind delta_sleep_queue dsq_checker u_dsq_checker (.*);

// File: bench/tb_delta_sleep_queue.sv
// ----------------------------------------------------------------------------
// tb_delta_sleep_queue
// checks the delta-list sleep queue: every request is mirrored in a local
// copy of the list, and each result on the output stream is compared field
// by field against the oldest predicted one. directed tests cover empty,
// full, equal wake times, tick saturation and bad positions; random traffic
// in fill, drain, tick-heavy and mixed bursts runs under three idle profiles,
// and a separate test covers one long output stall.
// ----------------------------------------------------------------------------
module tb_delta_sleep_queue;
  import dsq_pkg::*;

  localparam int QUEUE_DEPTH    = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;

  typedef struct packed {
    logic [15:0] taken_id;
    logic        taken_valid;
    logic [15:0] head_id;
    logic [15:0] head_remaining;
    logic        head_valid;
    logic [6:0]  entry_count;
    dsq_status_t status;
  } sleep_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;   // thread_id, delay, position, pad
  logic [1:0]       in_tuser = '0;   // op
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;       // taken_id, taken_valid, head_id,
                                     // head_remaining, head_valid,
                                     // entry_count, status, pad

  logic [15:0]   sleeper_id_copy[QUEUE_DEPTH];
  logic [15:0]   sleeper_delta_copy[QUEUE_DEPTH];
  int            sleeper_count = 0;
  sleep_result_t pending_results[$];
  int            mismatch_count = 0;
  int            tx_idle_pct = 0;
  int            rx_idle_pct = 0;
  int            rx_hold_left = 0;
  int            quiet_cycles = 0;

  delta_sleep_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (16)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pull one entry out of the list and fold its delta into the successor
  function automatic logic [15:0] unlink_sleeper(int at);
    logic [15:0] id;
    logic [16:0] sum;
    int          k;
    id = sleeper_id_copy[at];
    if (at + 1 < sleeper_count) begin
      sum = {1'b0, sleeper_delta_copy[at + 1]} + {1'b0, sleeper_delta_copy[at]};
      sleeper_delta_copy[at + 1] = sum[16] ? 16'hFFFF : sum[15:0];
    end
    for (k = at; k + 1 < sleeper_count; k++) begin
      sleeper_id_copy[k]    = sleeper_id_copy[k + 1];
      sleeper_delta_copy[k] = sleeper_delta_copy[k + 1];
    end
    sleeper_count--;
    return id;
  endfunction

  function automatic sleep_result_t predict_sleep_result(dsq_op_t op, logic [15:0] tid,
                                                          logic [15:0] dly, logic [5:0] pos);
    sleep_result_t r;
    logic [15:0]   t;
    int            p;
    int            k;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (sleeper_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          p = 0;
          t = dly;
          while (p < sleeper_count && t > sleeper_delta_copy[p]) begin
            t -= sleeper_delta_copy[p];
            p++;
          end
          for (k = sleeper_count; k > p; k--) begin
            sleeper_id_copy[k]    = sleeper_id_copy[k - 1];
            sleeper_delta_copy[k] = sleeper_delta_copy[k - 1];
          end
          sleeper_id_copy[p]    = tid;
          sleeper_delta_copy[p] = t;
          sleeper_count++;
          if (p + 1 < sleeper_count) sleeper_delta_copy[p + 1] -= t;
        end
      end
      OP_TICK: begin
        if (sleeper_count == 0) r.status = ST_EMPTY;
        else if (sleeper_delta_copy[0] != 16'd0) sleeper_delta_copy[0]--;
      end
      OP_TAKE: begin
        if (sleeper_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.taken_id    = unlink_sleeper(0);
          r.taken_valid = 1'b1;
        end
      end
      default: begin
        if (sleeper_count == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(pos) >= sleeper_count) begin
          r.status = ST_BAD_POS;
        end else begin
          r.taken_id    = unlink_sleeper(int'(pos));
          r.taken_valid = 1'b1;
        end
      end
    endcase
    if (sleeper_count != 0) begin
      r.head_id        = sleeper_id_copy[0];
      r.head_remaining = sleeper_delta_copy[0];
      r.head_valid     = 1'b1;
    end
    r.entry_count = 7'(sleeper_count);
    return r;
  endfunction

  task automatic send_request(dsq_op_t op, logic [15:0] tid, logic [15:0] dly,
                              logic [5:0] pos);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, pos, dly, tid};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_sleep_result(op, tid, dly, pos));
  endtask

  function automatic logic [15:0] random_delay();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(15));
      1:       return 16'($urandom_range(300));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_checker
    sleep_result_t want;
    sleep_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.taken_id       = out_tdata[15:0];
      got.taken_valid    = out_tdata[16];
      got.head_id        = out_tdata[32:17];
      got.head_remaining = out_tdata[48:33];
      got.head_valid     = out_tdata[49];
      got.entry_count    = out_tdata[56:50];
      got.status         = dsq_status_t'(out_tdata[58:57]);
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("taken_id", want.taken_id, got.taken_id);
        check_field("taken_valid", want.taken_valid, got.taken_valid);
        check_field("head_id", want.head_id, got.head_id);
        check_field("head_remaining", want.head_remaining, got.head_remaining);
        check_field("head_valid", want.head_valid, got.head_valid);
        check_field("entry_count", want.entry_count, got.entry_count);
        check_field("status", want.status, got.status);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_tready   <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_empty_queue();
    send_request(OP_TICK, 16'h1234, 16'h0010, 6'd0);
    send_request(OP_TAKE, 16'h0000, 16'h0000, 6'd0);
    send_request(OP_REMOVE, 16'hFFFF, 16'hFFFF, 6'd0);
  endtask

  task automatic test_insert_order();
    send_request(OP_INSERT, 16'hFFFF, 16'hFFFF, 6'd63);
    send_request(OP_INSERT, 16'h0000, 16'h0000, 6'd0);
    send_request(OP_INSERT, 16'h5A5A, 16'd100, 6'd21);
    // equal wake time lands ahead of the earlier one
    send_request(OP_INSERT, 16'hA5A5, 16'd100, 6'd42);
    send_request(OP_INSERT, 16'h0F0F, 16'hFFFF, 6'd7);
    send_request(OP_INSERT, 16'h00FF, 16'd0, 6'd56);
  endtask

  task automatic test_tick();
    // head sits at zero, tick must saturate
    send_request(OP_TICK, 16'h0000, 16'h0000, 6'd0);
    send_request(OP_TAKE, 16'h0000, 16'h0000, 6'd0);
    send_request(OP_TAKE, 16'h0000, 16'h0000, 6'd0);
    send_request(OP_TICK, 16'hFFFF, 16'hFFFF, 6'd63);
    send_request(OP_TICK, 16'h0000, 16'h0000, 6'd0);
  endtask

  task automatic test_remove_positions();
    send_request(OP_REMOVE, 16'h0000, 16'h0000, 6'd63);
    send_request(OP_REMOVE, 16'h0000, 16'h0000, 6'(sleeper_count));
    send_request(OP_INSERT, 16'h1111, 16'd5000, 6'd0);
    send_request(OP_REMOVE, 16'h0000, 16'h0000, 6'd1);
    send_request(OP_REMOVE, 16'h0000, 16'h0000, 6'(sleeper_count - 1));
    send_request(OP_REMOVE, 16'h0000, 16'h0000, 6'd0);
    send_request(OP_TAKE, 16'h0000, 16'h0000, 6'd0);
    send_request(OP_TAKE, 16'h0000, 16'h0000, 6'd0);
  endtask

  task automatic test_full_queue();
    while (sleeper_count < QUEUE_DEPTH)
      send_request(OP_INSERT, 16'($urandom_range(65535)), random_delay(),
                   6'($urandom_range(63)));
    send_request(OP_INSERT, 16'($urandom_range(65535)), random_delay(), 6'd0);
    while (sleeper_count > 0) begin
      if ($urandom_range(1) == 0)
        send_request(OP_TAKE, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     6'($urandom_range(63)));
      else
        send_request(OP_REMOVE, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     6'($urandom_range(sleeper_count - 1)));
    end
    send_request(OP_TAKE, 16'h0000, 16'h0000, 6'd0);
  endtask

  task automatic test_output_stall();
    int n;
    rx_hold_left = 300;
    for (n = 0; n < 24; n++)
      send_request(n % 5 == 4 ? OP_TICK : OP_INSERT, 16'($urandom_range(65535)),
                   random_delay(), 6'($urandom_range(63)));
  endtask

  task automatic test_random_traffic(int n_requests);
    int          sent;
    int          burst_left;
    int          mode;
    int          roll;
    dsq_op_t     op;
    logic [5:0]  pos;
    sent = 0;
    burst_left = 0;
    mode = 0;
    while (sent < n_requests) begin
      if (burst_left == 0) begin
        mode = $urandom_range(3);
        burst_left = $urandom_range(40, 10);
      end
      roll = $urandom_range(99);
      case (mode)
        // fill
        0: op = roll < 75 ? OP_INSERT : roll < 85 ? OP_TICK : roll < 93 ? OP_TAKE : OP_REMOVE;
        // drain
        1: op = roll < 15 ? OP_INSERT : roll < 30 ? OP_TICK : roll < 65 ? OP_TAKE : OP_REMOVE;
        // timer heavy
        2: op = roll < 25 ? OP_INSERT : roll < 80 ? OP_TICK : roll < 90 ? OP_TAKE : OP_REMOVE;
        default: op = dsq_op_t'(roll % 4);
      endcase
      if (op == OP_REMOVE && sleeper_count > 0 && $urandom_range(9) < 8)
        pos = 6'($urandom_range(sleeper_count - 1));
      else
        pos = 6'($urandom_range(63));
      send_request(op, 16'($urandom_range(65535)), random_delay(), pos);
      sent++;
      burst_left--;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 22;
    rx_idle_pct = 72;
    test_empty_queue();
    test_insert_order();
    test_tick();
    test_remove_positions();
    test_full_queue();
    test_output_stall();
    test_random_traffic(230);

    tx_idle_pct = 72;
    rx_idle_pct = 22;
    test_random_traffic(230);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(230);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/dsq_pkg.sv
sv/delta_sleep_queue.sv
sv/dsq_checker.sv
bench/tb_delta_sleep_queue.sv
